// ===== hw/rtl/bmp565_pkg.sv =====
// Shared constants and types for the 24-bit BMP to RGB565 stream decoder.
// No dependencies; the pixel interface and the decoder use this package.
package bmp565_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int ADDR_W  = 20;
  localparam int COLOR_W = 16;
  localparam int KIND_W  = 2;
  localparam int POS_W   = 32;

  // Byte positions of the header fields (last byte of each field)
  localparam logic [POS_W-1:0] POS_MAGIC  = 32'd1;
  localparam logic [POS_W-1:0] POS_OFFSET = 32'd13;
  localparam logic [POS_W-1:0] POS_WIDTH  = 32'd21;
  localparam logic [POS_W-1:0] POS_HEIGHT = 32'd25;
  localparam logic [POS_W-1:0] POS_PLANES = 32'd27;
  localparam logic [POS_W-1:0] POS_BPP    = 32'd29;
  localparam logic [POS_W-1:0] POS_LAST   = 32'd33;

  localparam logic [15:0] BMP_MAGIC  = 16'h4D42;
  localparam logic [15:0] BMP_PLANES = 16'd1;
  localparam logic [15:0] BMP_BPP    = 16'd24;

  typedef enum logic [KIND_W-1:0] {
    KIND_PIXEL     = 2'd0,
    KIND_BAD_MAGIC = 2'd1,
    KIND_FORMAT    = 2'd2,
    KIND_SIZE      = 2'd3
  } kind_t;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_SKIP   = 5'b00010,
    PH_PIXEL  = 5'b00100,
    PH_PAD    = 5'b01000,
    PH_DONE   = 5'b10000
  } phase_t;

endpackage

// ===== hw/rtl/bmp565_byte_if.sv =====
// Byte request channel: one BMP file byte plus a start-of-file mark.
// Does not depend on bmp565_pkg; widths are fixed.
interface bmp565_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       file_start;

  modport source (output valid, output data_byte, output file_start, input ready);
  modport sink   (input valid, input data_byte, input file_start, output ready);
endinterface

// ===== hw/rtl/bmp565_pix_if.sv =====
// Result request channel: one decoded pixel or one header error.
// Depends on bmp565_pkg for the field widths.
interface bmp565_pix_if;
  logic                          valid;
  logic                          ready;
  logic [bmp565_pkg::KIND_W-1:0]  kind;
  logic [bmp565_pkg::ADDR_W-1:0]  pixel_addr;
  logic [bmp565_pkg::COLOR_W-1:0] pixel_color;
  logic                          last_pixel;

  modport source (output valid, output kind, output pixel_addr, output pixel_color,
                  output last_pixel, input ready);
  modport sink   (input valid, input kind, input pixel_addr, input pixel_color,
                  input last_pixel, output ready);
endinterface

// ===== hw/rtl/bmp24_to_rgb565_stream.sv =====
// Streaming 24-bit BMP parser producing RGB565 pixels with bottom-up row flip.
// Depends on bmp565_pkg, bmp565_byte_if and bmp565_pix_if.
//
//   channel  | dir | payload                                       | handshake
//   bytes    | in  | data_byte[7:0], file_start                     | valid/ready
//   pixels   | out | kind[1:0], pixel_addr[19:0], pixel_color[15:0], | valid/ready
//            |     | last_pixel                                     |
//
// One byte per cycle while bytes.ready is high; each byte is parsed in the cycle it is
// taken, and any result is registered in the output register unless that is stalled.
// A second result register catches a result while the output is stalled;
// bytes are refused only while that register is occupied.
// The row base address is kept by one multiply at the end of the header and
// a subtract per row, so no division is used.
// rst is synchronous, active high, clears the parse state and both result valid flags.
module bmp24_to_rgb565_stream (
  input  logic                clk,
  input  logic                rst,
  bmp565_byte_if.sink         bytes,
  bmp565_pix_if.source        pixels
);

  localparam int DW = bmp565_pkg::DIM_W;
  localparam int AW = bmp565_pkg::ADDR_W;
  localparam int PW = bmp565_pkg::POS_W;
  localparam int CW = bmp565_pkg::COLOR_W;

  typedef struct packed {
    bmp565_pkg::kind_t kind;
    logic [AW-1:0]     addr;
    logic [CW-1:0]     color;
    logic              last;
  } result_t;

  // Parse state
  bmp565_pkg::phase_t phase, phase_next;
  logic [PW-1:0] byte_position, byte_position_next;
  logic [31:0]   field_assembly, field_assembly_next;
  logic [31:0]   data_offset, data_offset_next;
  logic [DW-1:0] image_width, image_width_next;
  logic [DW-1:0] image_height, image_height_next;
  logic [DW-1:0] column_count, column_count_next;
  logic [DW-1:0] row_count, row_count_next;
  logic [AW-1:0] row_base, row_base_next;
  logic [1:0]    byte_in_pixel, byte_in_pixel_next;
  logic [7:0]    blue_hold, blue_hold_next;
  logic [7:0]    green_hold, green_hold_next;
  logic [1:0]    pad_count, pad_count_next;

  // Result registers
  logic    out_valid, skid_valid;
  result_t out_reg, skid_reg;

  logic    in_fire, out_fire;
  logic    res_valid;
  result_t res;

  bmp565_pkg::phase_t eff_phase;
  logic [PW-1:0] eff_pos;
  logic [31:0]   fa_new;
  logic [PW-1:0] pos_inc;
  logic [AW-1:0] base_prod;
  logic          row_end, last_px;

  function automatic logic [DW-1:0] dim_or_zero(input logic [31:0] v);
    if (v == 32'd0 || v > 32'(bmp565_pkg::MAX_DIM)) begin
      return '0;
    end
    return v[DW-1:0];
  endfunction

  assign in_fire      = bytes.valid && bytes.ready;
  assign out_fire     = out_valid && pixels.ready;
  assign bytes.ready  = !skid_valid;

  assign pixels.valid       = out_valid;
  assign pixels.kind        = out_reg.kind;
  assign pixels.pixel_addr  = out_reg.addr;
  assign pixels.pixel_color = out_reg.color;
  assign pixels.last_pixel  = out_reg.last;

  // A start mark restarts the parse with this byte as byte 0
  assign eff_phase = bytes.file_start ? bmp565_pkg::PH_HEADER : phase;
  assign eff_pos   = bytes.file_start ? '0 : byte_position;
  assign fa_new    = {bytes.data_byte, (bytes.file_start ? 24'd0 : field_assembly[31:8])};
  assign pos_inc   = eff_pos + PW'(1);
  assign base_prod = AW'(image_height - DW'(1)) * AW'(image_width);
  assign row_end   = ({1'b0, column_count} + (DW+1)'(1)) >= {1'b0, image_width};
  assign last_px   = row_end && (({1'b0, row_count} + (DW+1)'(1)) >= {1'b0, image_height});

  always_comb begin
    phase_next          = phase;
    byte_position_next  = byte_position;
    field_assembly_next = field_assembly;
    data_offset_next    = data_offset;
    image_width_next    = image_width;
    image_height_next   = image_height;
    column_count_next   = column_count;
    row_count_next      = row_count;
    row_base_next       = row_base;
    byte_in_pixel_next  = byte_in_pixel;
    blue_hold_next      = blue_hold;
    green_hold_next     = green_hold;
    pad_count_next      = pad_count;
    res_valid           = 1'b0;
    res                 = '0;

    if (in_fire) begin
      if (bytes.file_start) begin
        phase_next          = bmp565_pkg::PH_HEADER;
        byte_position_next  = '0;
        field_assembly_next = '0;
        data_offset_next    = '0;
        image_width_next    = '0;
        image_height_next   = '0;
        column_count_next   = '0;
        row_count_next      = '0;
        byte_in_pixel_next  = '0;
        blue_hold_next      = '0;
        green_hold_next     = '0;
        pad_count_next      = '0;
      end

      case (eff_phase)
        bmp565_pkg::PH_HEADER: begin
          byte_position_next  = pos_inc;
          field_assembly_next = fa_new;
          if (eff_pos == bmp565_pkg::POS_MAGIC && fa_new[31:16] != bmp565_pkg::BMP_MAGIC) begin
            res_valid  = 1'b1;
            res.kind   = bmp565_pkg::KIND_BAD_MAGIC;
            phase_next = bmp565_pkg::PH_DONE;
          end else if (eff_pos == bmp565_pkg::POS_OFFSET) begin
            data_offset_next = fa_new;
          end else if (eff_pos == bmp565_pkg::POS_WIDTH) begin
            image_width_next = dim_or_zero(fa_new);
          end else if (eff_pos == bmp565_pkg::POS_HEIGHT) begin
            image_height_next = dim_or_zero(fa_new);
          end else if ((eff_pos == bmp565_pkg::POS_PLANES &&
                        fa_new[31:16] != bmp565_pkg::BMP_PLANES) ||
                       (eff_pos == bmp565_pkg::POS_BPP &&
                        fa_new[31:16] != bmp565_pkg::BMP_BPP)) begin
            res_valid  = 1'b1;
            res.kind   = bmp565_pkg::KIND_FORMAT;
            phase_next = bmp565_pkg::PH_DONE;
          end else if (eff_pos == bmp565_pkg::POS_LAST) begin
            if (fa_new != 32'd0) begin
              res_valid  = 1'b1;
              res.kind   = bmp565_pkg::KIND_FORMAT;
              phase_next = bmp565_pkg::PH_DONE;
            end else if (image_width == '0 || image_height == '0) begin
              res_valid  = 1'b1;
              res.kind   = bmp565_pkg::KIND_SIZE;
              phase_next = bmp565_pkg::PH_DONE;
            end else begin
              row_base_next = base_prod;
              phase_next    = (pos_inc >= data_offset) ? bmp565_pkg::PH_PIXEL
                                                       : bmp565_pkg::PH_SKIP;
            end
          end
        end

        bmp565_pkg::PH_SKIP: begin
          byte_position_next = pos_inc;
          if (pos_inc >= data_offset) begin
            phase_next = bmp565_pkg::PH_PIXEL;
          end
        end

        bmp565_pkg::PH_PIXEL: begin
          case (byte_in_pixel)
            2'd0: begin
              blue_hold_next     = bytes.data_byte;
              byte_in_pixel_next = 2'd1;
            end
            2'd1: begin
              green_hold_next    = bytes.data_byte;
              byte_in_pixel_next = 2'd2;
            end
            default: begin
              res_valid          = 1'b1;
              res.kind           = bmp565_pkg::KIND_PIXEL;
              res.addr           = AW'(column_count) + row_base;
              res.color          = {bytes.data_byte[7:3], green_hold[7:2], blue_hold[7:3]};
              res.last           = last_px;
              byte_in_pixel_next = 2'd0;
              if (last_px) begin
                phase_next = bmp565_pkg::PH_DONE;
              end else if (row_end) begin
                // step one row up in the frame; rows arrive bottom first
                column_count_next = '0;
                row_count_next    = row_count + DW'(1);
                row_base_next     = row_base - AW'(image_width);
                pad_count_next    = image_width[1:0];
                if (image_width[1:0] != 2'd0) begin
                  phase_next = bmp565_pkg::PH_PAD;
                end
              end else begin
                column_count_next = column_count + DW'(1);
              end
            end
          endcase
        end

        bmp565_pkg::PH_PAD: begin
          pad_count_next = pad_count - 2'd1;
          if (pad_count == 2'd1) begin
            phase_next = bmp565_pkg::PH_PIXEL;
          end
        end

        default: begin
          // done: drop bytes until the next start mark
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= bmp565_pkg::PH_HEADER;
      byte_position  <= '0;
      field_assembly <= '0;
      data_offset    <= '0;
      image_width    <= '0;
      image_height   <= '0;
      column_count   <= '0;
      row_count      <= '0;
      row_base       <= '0;
      byte_in_pixel  <= '0;
      blue_hold      <= '0;
      green_hold     <= '0;
      pad_count      <= '0;
    end else begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      field_assembly <= field_assembly_next;
      data_offset    <= data_offset_next;
      image_width    <= image_width_next;
      image_height   <= image_height_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      row_base       <= row_base_next;
      byte_in_pixel  <= byte_in_pixel_next;
      blue_hold      <= blue_hold_next;
      green_hold     <= green_hold_next;
      pad_count      <= pad_count_next;
    end
  end

  // Output register with a catch register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      out_reg <= skid_valid ? skid_reg : res;
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("catch register full while output register empty");

  a_error_payload_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_reg.kind != bmp565_pkg::KIND_PIXEL) |->
      (out_reg.addr == '0 && out_reg.color == '0 && !out_reg.last))
    else $error("error result carries pixel payload");

  a_pixel_byte_index: assert property (@(posedge clk) disable iff (rst)
    (phase == bmp565_pkg::PH_PIXEL) |-> (byte_in_pixel != 2'd3))
    else $error("byte index within pixel out of range");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == bmp565_pkg::PH_PAD) |-> (pad_count != 2'd0))
    else $error("padding phase with no bytes left");

  a_column_in_row: assert property (@(posedge clk) disable iff (rst)
    (phase == bmp565_pkg::PH_PIXEL || phase == bmp565_pkg::PH_PAD) |->
      (column_count < image_width && row_count < image_height))
    else $error("pixel position outside the image");

endmodule
